// ===== design/odgs_pkg.sv =====
package odgs_pkg;

  // Block dimensions
  localparam int MaxSegments = 16;
  localparam int LegCount    = 4;
  localparam int OutLegs     = 4;
  localparam int LegW        = (LegCount > 1) ? $clog2(LegCount) : 1;

  // Field and register widths
  localparam int NumW     = 32;
  localparam int SegCntW  = 5;
  localparam int IpsW     = 8;
  localparam int ByteW    = 8;
  localparam int LegRegW  = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int CountW   = $clog2(MaxSegments + 1);
  localparam int SegW     = 4;
  localparam int PeriodW  = $clog2(MaxSegments * 255 + 1);
  localparam int DurTickW = 2 * ByteW;
  localparam int QFracW   = 16;
  localparam int ProgW    = QFracW + 1;
  localparam int DenW     = 16;
  localparam int QuoW     = ProgW;
  localparam int IterW    = $clog2(NumW + 1);
  localparam int TdataW   = 152;

  // Register reset values
  localparam logic [SegCntW-1:0]  SegCountRst = SegCntW'(10);
  localparam logic [IpsW-1:0]     IpsRst      = IpsW'(1);
  localparam logic [LegRegW-1:0]  OffsetsRst  = 32'h0005_0500;
  localparam logic [LegRegW-1:0]  DurationsRst = 32'h0505_0505;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSegmentCount  = 2'd0,
    CfgItersPerSeg   = 2'd1,
    CfgLegOffsets    = 2'd2,
    CfgLegDurations  = 2'd3
  } cfg_idx_e;

  // Operations run on the shared divider
  typedef enum logic [2:0] {
    DivMod,
    DivSeg,
    DivOff,
    DivStance,
    DivSwing
  } div_op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StMod,
    StModWait,
    StSeg,
    StSegWait,
    StOff,
    StOffWait,
    StLegMul,
    StLegWin,
    StStance,
    StStanceWait,
    StSwing,
    StSwingWait,
    StRows
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_tick;
    logic            div_start;
    div_op_e         div_op;
    logic [LegW-1:0] leg;
    logic            leg_mul;
    logic            leg_win;
    logic            row_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
    logic row_last;
  } dp_status_t;

endpackage

// ===== design/offset_duration_gait_scheduler_core.sv =====
// Gait phase scheduler. Each input transaction carries a control tick count;
// for it the block returns one output transaction per horizon row, as many
// as the effective segment count (segment_count clamped to 1..16), each
// holding the row's four-leg contact mask together with the per-leg
// stance and swing progress (Q1.16) and the current segment, with tlast on
// the final row. Work on a tick is done by one shared bit-serial divider that
// produces one quotient bit per cycle: the tick modulo the period, the
// segment number, four offset reductions and up to eight progress
// divisions, fewer when stance or swing windows are empty or t lies outside
// them. Input tready is high only between ticks; the next tick is taken as
// soon as the last row sits in the output register. Configuration writes are
// meant for idle periods.
module offset_duration_gait_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [odgs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [odgs_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Tick input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] current_iteration
  input  logic [odgs_pkg::NumW-1:0]     s_axis_tdata_i,
  // Horizon row output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [3:0] row_index, [7:4] horizon_contact, [24:8] contact_progress_leg0,
  // [41:25] contact_progress_leg1, [58:42] contact_progress_leg2,
  // [75:59] contact_progress_leg3, [92:76] swing_progress_leg0,
  // [109:93] swing_progress_leg1, [126:110] swing_progress_leg2,
  // [143:127] swing_progress_leg3, [147:144] current_segment, [151:148] zero
  output logic [odgs_pkg::TdataW-1:0]   m_axis_tdata_o,
  // last_row
  output logic                          m_axis_tlast_o
);
  import odgs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  odgs_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, arithmetic and output stage
  odgs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== design/odgs_divider.sv =====
module odgs_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [odgs_pkg::NumW-1:0]  num_i,
  input  logic [odgs_pkg::DenW-1:0]  den_i,
  input  logic [odgs_pkg::IterW-1:0] iters_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [odgs_pkg::QuoW-1:0]  quo_o,
  output logic [odgs_pkg::DenW-1:0]  rem_o
);
  import odgs_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [IterW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [DenW:0]    trial;
  logic             ge;

  // One restoring step per cycle. The bits above the low iters_i bits of the
  // numerator seed the partial remainder; the caller keeps them below den_i.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, num_q[NumW-1]};
    ge     = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      num_d  = num_i << (IterW'(NumW) - iters_i);
      den_d  = den_i;
      rem_d  = DenW'(num_i >> iters_i);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quo_d = {quo_q[QuoW-2:0], ge};
      num_d = num_q << 1;
      cnt_d = cnt_q - IterW'(1);
      if (cnt_q == IterW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // A new division is never requested while one is still running.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

  // A finished division leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q)) else $error("divider remainder out of range");

  // Completion is flagged only once the unit has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

  // The unit only becomes busy in response to a start request.
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(start_i)) else $error("divider busy without start");

endmodule

// ===== design/odgs_datapath.sv =====
module odgs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odgs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [odgs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [odgs_pkg::NumW-1:0]     tick_i,
  input  odgs_pkg::dp_cmd_t             cmd_i,
  output odgs_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [odgs_pkg::TdataW-1:0]   out_data_o,
  output logic                          out_last_o
);
  import odgs_pkg::*;

  // Configuration registers
  logic [SegCntW-1:0] seg_cnt_q;
  logic [IpsW-1:0]    ips_q;
  logic [LegRegW-1:0] offs_cfg_q;
  logic [LegRegW-1:0] durs_cfg_q;

  // Working registers for one tick
  logic [NumW-1:0]     tick_q;
  logic [PeriodW-1:0]  period_q;
  logic [PeriodW-1:0]  t_q;
  logic [SegW-1:0]     seg_q;
  logic [SegW-1:0]     off_q    [LegCount];
  logic [ProgW-1:0]    stance_q [LegCount];
  logic [ProgW-1:0]    swing_q  [LegCount];
  logic [PeriodW-1:0]  ot_q;
  logic [DurTickW-1:0] dt_q;
  logic [PeriodW-1:0]  st_q;
  logic [PeriodW-1:0]  sl_q;
  logic                swing_ok_q;
  logic                skip_q;
  div_op_e             op_q;
  logic [LegW-1:0]     leg_sel_q;
  logic [SegW-1:0]     row_q;

  // Output register
  logic               out_valid_q;
  logic [SegW-1:0]    out_row_q;
  logic [OutLegs-1:0] out_mask_q;
  logic [ProgW-1:0]   out_stance_q [OutLegs];
  logic [ProgW-1:0]   out_swing_q  [OutLegs];
  logic [SegW-1:0]    out_seg_q;
  logic               out_last_q;

  logic [CountW-1:0]       n_eff;
  logic [IpsW-1:0]         ips_eff;
  logic [IpsW+CountW-1:0]  period_full;
  logic [ByteW-1:0]        off_byte;
  logic [ByteW-1:0]        dur_byte;
  logic [PeriodW-1:0]      d_stance;
  logic [PeriodW-1:0]      d_swing;
  logic [PeriodW:0]        wrap_tmp_a;
  logic [PeriodW:0]        wrap_tmp_b;
  logic                    skip;
  logic [NumW-1:0]         div_num;
  logic [DenW-1:0]         div_den;
  logic [IterW-1:0]        div_iters;
  logic                    div_go;
  logic                    div_busy;
  logic                    div_done;
  logic [QuoW-1:0]         div_quo;
  logic [DenW-1:0]         div_rem;
  logic                    done;
  logic [DurTickW:0]       st_sum;
  logic [DurTickW+1:0]     st_diff;
  logic [CountW:0]         fsum;
  logic [CountW-1:0]       future;
  logic [CountW:0]         pdist;
  logic [OutLegs-1:0]      mask;
  logic                    row_last;
  logic                    out_free;

  // Effective segment count and ticks per segment
  always_comb begin
    if (seg_cnt_q == '0) begin
      n_eff = CountW'(1);
    end else if (int'(seg_cnt_q) > MaxSegments) begin
      n_eff = CountW'(MaxSegments);
    end else begin
      n_eff = CountW'(seg_cnt_q);
    end
    ips_eff     = (ips_q == '0) ? IpsW'(1) : ips_q;
    period_full = (IpsW+CountW)'(ips_eff) * (IpsW+CountW)'(n_eff);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q  <= SegCountRst;
      ips_q      <= IpsRst;
      offs_cfg_q <= OffsetsRst;
      durs_cfg_q <= DurationsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSegmentCount: seg_cnt_q  <= cfg_wdata_i[SegCntW-1:0];
        CfgItersPerSeg:  ips_q      <= cfg_wdata_i[IpsW-1:0];
        CfgLegOffsets:   offs_cfg_q <= cfg_wdata_i[LegRegW-1:0];
        CfgLegDurations: durs_cfg_q <= cfg_wdata_i[LegRegW-1:0];
        default: ;
      endcase
    end
  end

  // Wrapped distance of t past the stance and swing window starts
  always_comb begin
    off_byte   = offs_cfg_q[cmd_i.leg*ByteW +: ByteW];
    dur_byte   = durs_cfg_q[cmd_i.leg*ByteW +: ByteW];
    wrap_tmp_a = {1'b0, t_q} + {1'b0, period_q} - {1'b0, ot_q};
    wrap_tmp_b = {1'b0, t_q} + {1'b0, period_q} - {1'b0, st_q};
    d_stance   = (t_q >= ot_q) ? (t_q - ot_q) : PeriodW'(wrap_tmp_a);
    d_swing    = (t_q >= st_q) ? (t_q - st_q) : PeriodW'(wrap_tmp_b);
  end

  // Divider operand selection
  always_comb begin
    skip      = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    case (cmd_i.div_op)
      DivMod: begin
        div_num   = tick_q;
        div_den   = DenW'(period_q);
        div_iters = IterW'(NumW);
      end
      DivSeg: begin
        div_num   = NumW'(t_q);
        div_den   = DenW'(ips_eff);
        div_iters = IterW'(SegW);
      end
      DivOff: begin
        div_num   = NumW'(off_byte);
        div_den   = DenW'(n_eff);
        div_iters = IterW'(ByteW);
      end
      DivStance: begin
        div_num   = NumW'({d_stance, {QFracW{1'b0}}});
        div_den   = DenW'(dt_q);
        div_iters = IterW'(ProgW);
        skip      = (dt_q == '0) || (DurTickW'(d_stance) > dt_q);
      end
      DivSwing: begin
        div_num   = NumW'({d_swing, {QFracW{1'b0}}});
        div_den   = DenW'(sl_q);
        div_iters = IterW'(ProgW);
        skip      = !swing_ok_q || (d_swing > sl_q);
      end
      default: ;
    endcase
    div_go = cmd_i.div_start && !skip;
  end

  odgs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign done = div_done || skip_q;

  // Swing window start from the stance window
  always_comb begin
    st_sum  = {1'b0, dt_q} + (DurTickW+1)'(ot_q);
    st_diff = {1'b0, st_sum} - (DurTickW+2)'(period_q);
  end

  // Horizon contact mask and last-row flag for the row about to be loaded, and output-free flag
  always_comb begin
    fsum   = (CountW+1)'(row_q) + (CountW+1)'(seg_q) + (CountW+1)'(1);
    future = (fsum >= {1'b0, n_eff}) ? CountW'(fsum - {1'b0, n_eff}) : CountW'(fsum);
    mask   = '0;
    pdist  = '0;
    for (int j = 0; j < LegCount; j++) begin
      if (future >= CountW'(off_q[j])) begin
        pdist = (CountW+1)'(future) - (CountW+1)'(off_q[j]);
      end else begin
        pdist = (CountW+1)'(future) + (CountW+1)'(n_eff) - (CountW+1)'(off_q[j]);
      end
      mask[j] = (ByteW'(pdist) < durs_cfg_q[j*ByteW +: ByteW]);
    end
    row_last = (CountW'(row_q) == (n_eff - CountW'(1)));
    out_free = !out_valid_q || out_ready_i;
  end

  // Control registers of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      skip_q <= cmd_i.div_start && skip;
      if (cmd_i.load_tick) begin
        row_q <= '0;
      end else if (cmd_i.row_load) begin
        row_q <= row_q + SegW'(1);
      end
      if (cmd_i.row_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tick) begin
      tick_q   <= tick_i;
      period_q <= PeriodW'(period_full);
    end
    if (cmd_i.div_start) begin
      op_q      <= cmd_i.div_op;
      leg_sel_q <= cmd_i.leg;
    end
    if (cmd_i.leg_mul) begin
      ot_q <= PeriodW'(off_q[cmd_i.leg]) * PeriodW'(ips_eff);
      dt_q <= DurTickW'(dur_byte) * DurTickW'(ips_eff);
    end
    if (cmd_i.leg_win) begin
      swing_ok_q <= (dt_q < DurTickW'(period_q));
      sl_q       <= PeriodW'(DurTickW'(period_q) - dt_q);
      st_q       <= st_diff[DurTickW+1] ? PeriodW'(st_sum) : PeriodW'(st_diff);
    end
    if (done) begin
      case (op_q)
        DivMod:    t_q   <= PeriodW'(div_rem);
        DivSeg:    seg_q <= div_quo[SegW-1:0];
        DivOff:    off_q[leg_sel_q] <= div_rem[SegW-1:0];
        DivStance: stance_q[leg_sel_q] <= skip_q ? '0 : div_quo;
        DivSwing:  swing_q[leg_sel_q]  <= skip_q ? '0 : div_quo;
        default: ;
      endcase
    end
  end

  // Output register load
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_load) begin
      out_row_q  <= row_q;
      out_mask_q <= mask;
      out_seg_q  <= seg_q;
      out_last_q <= row_last;
      for (int j = 0; j < OutLegs; j++) begin
        if (j < LegCount) begin
          out_stance_q[j] <= stance_q[j];
          out_swing_q[j]  <= swing_q[j];
        end else begin
          out_stance_q[j] <= '0;
          out_swing_q[j]  <= '0;
        end
      end
    end
  end

  assign status_o.div_done = done;
  assign status_o.out_free = out_free && !div_busy;
  assign status_o.row_last = row_last;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {(TdataW-148)'(0), out_seg_q,
                        out_swing_q[3], out_swing_q[2], out_swing_q[1], out_swing_q[0],
                        out_stance_q[3], out_stance_q[2], out_stance_q[1], out_stance_q[0],
                        out_mask_q, out_row_q};

endmodule

// ===== design/odgs_controller.sv =====
module odgs_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  odgs_pkg::dp_status_t status_i,
  output odgs_pkg::dp_cmd_t    cmd_o
);
  import odgs_pkg::*;

  state_e          state_q, state_d;
  logic [LegW-1:0] leg_q, leg_d;
  logic            last_leg;

  assign last_leg = (leg_q == LegW'(LegCount - 1));

  // State and leg counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      leg_q   <= '0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    leg_d      = leg_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.div_op = DivMod;
    cmd_o.leg  = leg_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_tick = 1'b1;
          state_d = StMod;
        end
      end
      StMod: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivMod;
        state_d = StModWait;
      end
      StModWait: begin
        if (status_i.div_done) begin
          state_d = StSeg;
        end
      end
      StSeg: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivSeg;
        state_d = StSegWait;
      end
      StSegWait: begin
        if (status_i.div_done) begin
          leg_d   = '0;
          state_d = StOff;
        end
      end
      StOff: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivOff;
        state_d = StOffWait;
      end
      StOffWait: begin
        if (status_i.div_done) begin
          state_d = StLegMul;
        end
      end
      StLegMul: begin
        cmd_o.leg_mul = 1'b1;
        state_d = StLegWin;
      end
      StLegWin: begin
        cmd_o.leg_win = 1'b1;
        state_d = StStance;
      end
      StStance: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivStance;
        state_d = StStanceWait;
      end
      StStanceWait: begin
        if (status_i.div_done) begin
          state_d = StSwing;
        end
      end
      StSwing: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivSwing;
        state_d = StSwingWait;
      end
      StSwingWait: begin
        if (status_i.div_done) begin
          if (last_leg) begin
            state_d = StRows;
          end else begin
            leg_d   = leg_q + LegW'(1);
            state_d = StOff;
          end
        end
      end
      StRows: begin
        if (status_i.out_free) begin
          cmd_o.row_load = 1'b1;
          if (status_i.row_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule
